/* design/masked_softmax_cross_entropy_core_assert.svh */
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks, one with reset qualification and one without
// ----------------------------------------------------------------------------
`ifndef MASKED_SOFTMAX_CROSS_ENTROPY_CORE_ASSERT_SVH
`define MASKED_SOFTMAX_CROSS_ENTROPY_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define MSCE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MSCE_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSCE_ASSERT(lbl, clk, rst_n, prop, msg)
`define MSCE_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

/* design/msce_pkg.sv */
// ----------------------------------------------------------------------------
// msce_pkg
// shared constants, exp tables, and controller/datapath command types
// ----------------------------------------------------------------------------
package msce_pkg;

  localparam int unsigned MAX_CLASSES_DEF = 64;

  localparam logic [31:0] ONE21     = 32'h0020_0000;
  localparam logic [35:0] LN2_Q31   = 36'd1488522236;
  localparam logic [24:0] LOSS_CAP  = 25'd1207218;
  localparam logic [15:0] EXP_LIMIT = 16'd6144;
  localparam logic [63:0] MEAN_MAX  = 64'd134217727;
  localparam logic [3:0]  TERM_LAST = 4'd12;

  typedef logic [23:0][31:0]  exp_a_tab_t;
  typedef logic [255:0][31:0] exp_b_tab_t;

  typedef enum logic [1:0] {
    DIV_LN,
    DIV_TERM,
    DIV_MEAN
  } div_op_e;

  typedef struct packed {
    logic    accept;
    logic    exp_mul;
    logic    exp_acc;
    logic    count_inc;
    logic    div_start;
    div_op_e div_op;
    logic    z_load;
    logic    z2_load;
    logic    term_mul;
    logic    term_acc;
    logic    ln_final;
    logic    walk_acc;
    logic    row_clear;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic in_go;
    logic in_end;
    logic item_end;
    logic row_masked;
    logic set_end;
    logic j_last;
    logic walk_last;
    logic count_zero;
    logic div_done;
    logic out_busy;
  } sts_t;

  // exp(-f/256) in Q1.31, truncated taylor series
  function automatic logic [63:0] exp_piece(input logic [8:0] f);
    logic [63:0] t;
    logic [63:0] pos;
    logic [63:0] neg;
    t   = 64'd1 << 31;
    pos = t;
    neg = '0;
    for (int n = 1; n <= 16; n++) begin
      t = (t * {55'd0, f}) / 64'(256 * n);
      if ((n % 2) == 1) begin
        neg = neg + t;
      end else begin
        pos = pos + t;
      end
    end
    return pos - neg;
  endfunction

  function automatic exp_a_tab_t build_exp_a();
    exp_a_tab_t  tab;
    logic [63:0] p;
    logic [63:0] em1;
    p   = 64'd1 << 31;
    em1 = exp_piece(9'd256);
    for (int i = 0; i < 24; i++) begin
      tab[i] = p[31:0];
      p = (p * em1 + (64'd1 << 30)) >> 31;
    end
    return tab;
  endfunction

  function automatic exp_b_tab_t build_exp_b();
    exp_b_tab_t  tab;
    logic [63:0] v;
    for (int i = 0; i < 256; i++) begin
      v = exp_piece(9'(i));
      tab[i] = v[31:0];
    end
    return tab;
  endfunction

  localparam exp_a_tab_t EXP_A = build_exp_a();
  localparam exp_b_tab_t EXP_B = build_exp_b();

endpackage

/* design/msce_stream_if.sv */
// ----------------------------------------------------------------------------
// msce stream interfaces
// valid/ready channels for logit items and loss results
// ----------------------------------------------------------------------------
interface msce_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] logit;
  logic               is_labeled;
  logic               sample_masked;
  logic               last_in_sample;
  logic               last_in_set;

  modport source (
    output valid, logit, is_labeled, sample_masked, last_in_sample, last_in_set,
    input  ready
  );
  modport sink (
    input  valid, logit, is_labeled, sample_masked, last_in_sample, last_in_set,
    output ready
  );
endinterface

interface msce_out_if;
  logic        valid;
  logic        ready;
  logic [26:0] mean_loss;
  logic        no_masked_samples;
  logic        saturated;

  modport source (
    output valid, mean_loss, no_masked_samples, saturated,
    input  ready
  );
  modport sink (
    input  valid, mean_loss, no_masked_samples, saturated,
    output ready
  );
endinterface

/* design/msce_div.sv */
// ----------------------------------------------------------------------------
// msce_div
// restoring divider, one quotient bit per cycle, 64 or 32 steps
// ----------------------------------------------------------------------------
module msce_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        short_i,
  input  logic [63:0] num_i,
  input  logic [32:0] den_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic [63:0] num_q, num_d;
  logic [32:0] rem_q, rem_d;
  logic [32:0] den_q;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [33:0] rem_sh;
  logic        ge;

  always_comb begin
    rem_sh = {rem_q, num_q[63]};
    ge     = rem_sh >= {1'b0, den_q};
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      cnt_d  = short_i ? 7'd32 : 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[62:0], ge};
      rem_d = ge ? 33'(rem_sh - {1'b0, den_q}) : rem_sh[32:0];
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

/* design/msce_ctrl.sv */
// ----------------------------------------------------------------------------
// msce_ctrl
// sequencer for item update, row-end log and loss walk, and set-end mean
// ----------------------------------------------------------------------------
module msce_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  msce_pkg::sts_t sts_i,
  output msce_pkg::cmd_t cmd_o
);
  import msce_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE = 17'b00000000000000001,
    S_EXP  = 17'b00000000000000010,
    S_ACC  = 17'b00000000000000100,
    S_REND = 17'b00000000000001000,
    S_LN0  = 17'b00000000000010000,
    S_LNW  = 17'b00000000000100000,
    S_Z2   = 17'b00000000001000000,
    S_TM   = 17'b00000000010000000,
    S_TDS  = 17'b00000000100000000,
    S_TDW  = 17'b00000001000000000,
    S_LNF  = 17'b00000010000000000,
    S_WRD  = 17'b00000100000000000,
    S_WACC = 17'b00001000000000000,
    S_RCLR = 17'b00010000000000000,
    S_QDIV = 17'b00100000000000000,
    S_QW   = 17'b01000000000000000,
    S_OUT  = 17'b10000000000000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    cmd_o.div_op = DIV_LN;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.in_go) begin
            state_d = S_EXP;
          end else if (sts_i.in_end) begin
            state_d = S_REND;
          end
        end
      end
      S_EXP: begin
        cmd_o.exp_mul = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.exp_acc = 1'b1;
        state_d = sts_i.item_end ? S_REND : S_IDLE;
      end
      S_REND: begin
        state_d = sts_i.row_masked ? S_LN0 : S_RCLR;
      end
      S_LN0: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_LN;
        cmd_o.count_inc = 1'b1;
        state_d = S_LNW;
      end
      S_LNW: begin
        if (sts_i.div_done) begin
          cmd_o.z_load = 1'b1;
          state_d = S_Z2;
        end
      end
      S_Z2: begin
        cmd_o.z2_load = 1'b1;
        state_d = S_TM;
      end
      S_TM: begin
        cmd_o.term_mul = 1'b1;
        state_d = S_TDS;
      end
      S_TDS: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_TERM;
        state_d = S_TDW;
      end
      S_TDW: begin
        if (sts_i.div_done) begin
          cmd_o.term_acc = 1'b1;
          state_d = sts_i.j_last ? S_LNF : S_TM;
        end
      end
      S_LNF: begin
        cmd_o.ln_final = 1'b1;
        state_d = S_WRD;
      end
      S_WRD: begin
        state_d = S_WACC;
      end
      S_WACC: begin
        cmd_o.walk_acc = 1'b1;
        state_d = sts_i.walk_last ? S_RCLR : S_WRD;
      end
      S_RCLR: begin
        cmd_o.row_clear = 1'b1;
        state_d = sts_i.set_end ? S_QDIV : S_IDLE;
      end
      S_QDIV: begin
        if (sts_i.count_zero) begin
          state_d = S_OUT;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_op    = DIV_MEAN;
          state_d = S_QW;
        end
      end
      S_QW: begin
        if (sts_i.div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/msce_dp.sv */
// ----------------------------------------------------------------------------
// msce_dp
// row buffer, exp sum, log series, loss walk, totals and result register
// ----------------------------------------------------------------------------
`include "masked_softmax_cross_entropy_core_assert.svh"

module msce_dp #(
  parameter int unsigned MAX_CLASSES = msce_pkg::MAX_CLASSES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  msce_pkg::cmd_t     cmd_i,
  output msce_pkg::sts_t     sts_o,
  input  logic signed [15:0] logit_i,
  input  logic               is_labeled_i,
  input  logic               sample_masked_i,
  input  logic               last_in_sample_i,
  input  logic               last_in_set_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [26:0]        mean_loss_o,
  output logic               no_masked_samples_o,
  output logic               saturated_o
);
  import msce_pkg::*;

  localparam int unsigned FW = $clog2(MAX_CLASSES + 1);
  localparam int unsigned AW = $clog2(MAX_CLASSES);

  // row buffer
  logic [16:0] mem [MAX_CLASSES];
  logic [16:0] rd_q;

  logic [FW-1:0]      fill_q;
  logic [FW-1:0]      walk_q;
  logic signed [15:0] row_max_q;
  logic [31:0]        sum_q;
  logic [47:0]        total_q;
  logic [20:0]        count_q;

  logic signed [15:0] x_q;
  logic               msk_q, end_q, set_q, gt_q;
  logic [30:0]        f_q;
  logic [3:0]         ln_k_q;
  logic               ln_small_q;
  logic [30:0]        z_q, z2_q, term_q;
  logic [31:0]        acc_q;
  logic [3:0]         j_q;
  logic [19:0]        base_q;

  logic               out_valid_q;
  logic [26:0]        mean_q;
  logic               nomask_q, sat_q;

  logic in_range, fill_zero, wr_en;

  assign in_range  = fill_q < FW'(MAX_CLASSES);
  assign fill_zero = (fill_q == '0);
  assign wr_en     = cmd_i.accept && in_range;

  // exp lookup and product
  logic signed [16:0] diff_up, diff_dn;
  logic               gt_now;
  logic [15:0]        exp_u;
  logic               exp_far;
  logic [4:0]         a_idx;
  logic [63:0]        ab_prod, ab_round;

  always_comb begin
    gt_now   = x_q > row_max_q;
    diff_up  = {x_q[15], x_q} - {row_max_q[15], row_max_q};
    diff_dn  = {row_max_q[15], row_max_q} - {x_q[15], x_q};
    exp_u    = gt_now ? diff_up[15:0] : diff_dn[15:0];
    exp_far  = exp_u >= EXP_LIMIT;
    a_idx    = exp_far ? 5'd0 : exp_u[12:8];
    ab_prod  = {32'd0, EXP_A[a_idx]} * {32'd0, EXP_B[exp_u[7:0]]};
    ab_round = ab_prod + (64'd1 << 31);
  end

  // sum update
  logic [62:0] resc_p;
  logic [33:0] resc_s;
  logic [31:0] add_t;
  logic [32:0] add_s;
  logic [31:0] sum_new;

  always_comb begin
    resc_p = {31'd0, sum_q} * {32'd0, f_q};
    resc_s = {1'b0, 33'(resc_p + (63'd1 << 29) >> 30)} + {2'b0, ONE21};
    add_t  = {1'b0, f_q} + 32'd256;
    add_s  = {1'b0, sum_q} + {10'd0, add_t[31:9]};
    if (gt_q) begin
      sum_new = (resc_s[33:32] != 2'b00) ? 32'hFFFF_FFFF : resc_s[31:0];
    end else begin
      sum_new = add_s[32] ? 32'hFFFF_FFFF : add_s[31:0];
    end
  end

  // log normalization
  logic [3:0]  ln_k;
  logic [31:0] ln_m;
  logic [31:0] ln_mf;

  always_comb begin
    ln_k = 4'd0;
    for (int b = 22; b <= 31; b++) begin
      if (sum_q[b]) begin
        ln_k = 4'(b - 21);
      end
    end
    ln_m  = sum_q << (4'd10 - ln_k);
    ln_mf = ln_m - 32'h8000_0000;
  end

  // divider operands
  logic [63:0] div_num;
  logic [32:0] div_den;
  logic        div_short;
  logic        div_busy, div_done;
  logic [63:0] div_quot;

  always_comb begin
    div_num   = {16'd0, total_q};
    div_den   = {12'd0, count_q};
    div_short = 1'b0;
    case (cmd_i.div_op)
      DIV_LN: begin
        div_num = {2'b00, ln_mf[30:0], 31'd0};
        div_den = {1'b0, ln_m} + 33'h0_8000_0000;
      end
      DIV_TERM: begin
        div_num   = {1'b0, term_q, 32'd0};
        div_den   = {28'd0, j_q, 1'b1};
        div_short = 1'b1;
      end
      DIV_MEAN: begin
        div_num = {16'd0, total_q};
        div_den = {12'd0, count_q};
      end
      default: begin
        div_num = {16'd0, total_q};
      end
    endcase
  end

  msce_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .short_i (div_short),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // series products and final log value
  logic [61:0] sq_p, tm_p;
  logic [35:0] ln_fin;

  assign sq_p   = {31'd0, z_q} * {31'd0, z_q};
  assign tm_p   = {31'd0, term_q} * {31'd0, z2_q};
  assign ln_fin = {32'd0, ln_k_q} * LN2_Q31 + {3'd0, acc_q, 1'b0} + 36'd16384;

  // loss walk
  logic signed [16:0] w_diff;
  logic [24:0]        w_t, w_cap;
  logic [48:0]        w_sum;
  logic [47:0]        total_walk;

  always_comb begin
    w_diff     = {row_max_q[15], row_max_q} - {rd_q[15], rd_q[15:0]};
    w_t        = {1'b0, w_diff[15:0], 8'd0} + {5'd0, base_q};
    w_cap      = (w_t > LOSS_CAP) ? LOSS_CAP : w_t;
    w_sum      = {1'b0, total_q} + {24'd0, w_cap};
    total_walk = w_sum[48] ? 48'hFFFF_FFFF_FFFF : w_sum[47:0];
  end

  always_comb begin
    sts_o.in_go      = in_range && !fill_zero;
    sts_o.in_end     = last_in_sample_i || last_in_set_i;
    sts_o.item_end   = end_q;
    sts_o.row_masked = !fill_zero && msk_q;
    sts_o.set_end    = set_q;
    sts_o.j_last     = (j_q == TERM_LAST);
    sts_o.walk_last  = (walk_q == fill_q - FW'(1));
    sts_o.count_zero = (count_q == '0);
    sts_o.div_done   = div_done;
    sts_o.out_busy   = out_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[fill_q[AW-1:0]] <= {is_labeled_i, logit_i};
    end
    rd_q <= mem[walk_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      row_max_q   <= 16'sh8000;
      sum_q       <= '0;
      total_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        fill_q <= fill_q + FW'(1);
        if (fill_zero) begin
          row_max_q <= logit_i;
          sum_q     <= ONE21;
        end
      end
      if (cmd_i.exp_acc) begin
        sum_q <= sum_new;
        if (gt_q) begin
          row_max_q <= x_q;
        end
      end
      if (cmd_i.count_inc && (count_q != '1)) begin
        count_q <= count_q + 21'd1;
      end
      if (cmd_i.walk_acc && rd_q[16]) begin
        total_q <= total_walk;
      end
      if (cmd_i.row_clear) begin
        fill_q    <= '0;
        row_max_q <= 16'sh8000;
        sum_q     <= '0;
      end
      if (cmd_i.out_load) begin
        total_q     <= '0;
        count_q     <= '0;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q   <= logit_i;
      msk_q <= sample_masked_i;
      end_q <= last_in_sample_i || last_in_set_i;
      set_q <= last_in_set_i;
    end
    if (cmd_i.exp_mul) begin
      gt_q <= gt_now;
      f_q  <= exp_far ? 31'd0 : ab_round[62:32];
    end
    if (cmd_i.div_start && (cmd_i.div_op == DIV_LN)) begin
      ln_k_q     <= ln_k;
      ln_small_q <= (sum_q < ONE21);
    end
    if (cmd_i.z_load) begin
      z_q <= div_quot[30:0];
    end
    if (cmd_i.z2_load) begin
      z2_q   <= sq_p[61:31];
      term_q <= z_q;
      acc_q  <= {1'b0, z_q};
      j_q    <= 4'd1;
    end
    if (cmd_i.term_mul) begin
      term_q <= tm_p[61:31];
    end
    if (cmd_i.term_acc) begin
      acc_q <= acc_q + div_quot[31:0];
      j_q   <= j_q + 4'd1;
    end
    if (cmd_i.ln_final) begin
      base_q <= ln_small_q ? 20'd0 : ln_fin[34:15];
      walk_q <= '0;
    end
    if (cmd_i.walk_acc) begin
      walk_q <= walk_q + FW'(1);
    end
    if (cmd_i.out_load) begin
      if (count_q == '0) begin
        mean_q   <= '0;
        nomask_q <= 1'b1;
        sat_q    <= 1'b0;
      end else begin
        nomask_q <= 1'b0;
        if (div_quot > MEAN_MAX) begin
          mean_q <= MEAN_MAX[26:0];
          sat_q  <= 1'b1;
        end else begin
          mean_q <= div_quot[26:0];
          sat_q  <= 1'b0;
        end
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign mean_loss_o         = mean_q;
  assign no_masked_samples_o = nomask_q;
  assign saturated_o         = sat_q;

  `MSCE_ASSERT(a_div_idle, clk_i, rst_ni, cmd_i.div_start |-> !div_busy, "divider restarted while busy")
  `MSCE_ASSERT(a_out_hold, clk_i, rst_ni, cmd_i.out_load |-> !out_valid_q, "pending result overwritten")
  `MSCE_ASSERT(a_walk_bound, clk_i, rst_ni, cmd_i.walk_acc |-> (walk_q < fill_q), "walk past row fill")
  `MSCE_ASSERT_NR(a_fill_bound, clk_i, !rst_ni || (fill_q <= FW'(MAX_CLASSES)), "row fill above buffer depth")

endmodule

/* design/masked_softmax_cross_entropy_core.sv */
// ----------------------------------------------------------------------------
// masked_softmax_cross_entropy_core
// streaming masked softmax cross-entropy loss with a set-end mean result
// ----------------------------------------------------------------------------
// Each logit goes through transfer, exp table lookup and multiply, and running
// sum update; logits that open a row or lie past MAX_CLASSES take transfer only.
// A masked row end adds the log of the exp sum on the shared bit-serial divider
// (64 steps for the normalized ratio, 32 for each of 12 series terms), then the
// loss walk through the row buffer read port, with read and accumulate states
// per buffered class. A set end adds the mean division. Input transfers are
// taken only between these sequences; a finished result waits in its output
// register, and a second result waits until the first is taken.
module masked_softmax_cross_entropy_core #(
  parameter int unsigned MAX_CLASSES = msce_pkg::MAX_CLASSES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  msce_in_if.sink    in_i,
  msce_out_if.source out_o
);
  import msce_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_i.ready = in_ready;

  msce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  msce_dp #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .logit_i             (in_i.logit),
    .is_labeled_i        (in_i.is_labeled),
    .sample_masked_i     (in_i.sample_masked),
    .last_in_sample_i    (in_i.last_in_sample),
    .last_in_set_i       (in_i.last_in_set),
    .out_valid_o         (out_o.valid),
    .out_ready_i         (out_o.ready),
    .mean_loss_o         (out_o.mean_loss),
    .no_masked_samples_o (out_o.no_masked_samples),
    .saturated_o         (out_o.saturated)
  );

endmodule
